// ----- design/dna_pkg.sv -----
// Shared types, constants and saturation helpers for the dual number ALU.
package dna_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int GRAD_LANES    = 3;
   localparam int FRAC_BITS_DEF = 16;

   // Quotient bits kept before rounding; anything at or above the top bit saturates
   localparam int QBITS      = DATA_W + 1;
   localparam int DIV_STAGES = QBITS + 1;

   localparam logic signed [DATA_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] NEG_LIMIT = 32'sh8000_0000;
   localparam logic [PROD_W-1:0] MAG_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [PROD_W-1:0] MAG_NEG = 64'h0000_0000_8000_0000;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK  = 2'd0,
      STAT_SAT = 2'd1,
      STAT_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] left_grad_0;
      logic signed [DATA_W-1:0] left_grad_1;
      logic signed [DATA_W-1:0] left_grad_2;
      logic signed [DATA_W-1:0] right_value;
      logic signed [DATA_W-1:0] right_grad_0;
      logic signed [DATA_W-1:0] right_grad_1;
      logic signed [DATA_W-1:0] right_grad_2;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic signed [DATA_W-1:0] result_grad_0;
      logic signed [DATA_W-1:0] result_grad_1;
      logic signed [DATA_W-1:0] result_grad_2;
      status_type               status;
   } rsp_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     clip;
   } sat_type;

   // Magnitude of a two's complement word; the most negative value maps to 2^31
   function automatic logic [DATA_W-1:0] abs32(logic signed [DATA_W-1:0] x);
      logic [DATA_W-1:0] r;
      r = x;
      return x[DATA_W-1] ? (~r + 32'd1) : r;
   endfunction

   // Clip a 33-bit sum to 32 bits
   function automatic sat_type sat_sum(logic signed [DATA_W:0] s);
      sat_type r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r.value = s[DATA_W] ? NEG_LIMIT : POS_LIMIT;
         r.clip  = 1'b1;
      end else begin
         r.value = s[DATA_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   // Clip a sign and magnitude pair to 32 bits
   function automatic sat_type sat_mag(logic neg, logic [PROD_W-1:0] mag);
      sat_type r;
      if (!neg) begin
         if (mag > MAG_POS) begin
            r.value = POS_LIMIT;
            r.clip  = 1'b1;
         end else begin
            r.value = mag[DATA_W-1:0];
            r.clip  = 1'b0;
         end
      end else begin
         if (mag > MAG_NEG) begin
            r.value = NEG_LIMIT;
            r.clip  = 1'b1;
         end else begin
            r.value = ~mag[DATA_W-1:0] + 32'd1;
            r.clip  = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

// ----- design/dna_div.sv -----
// Pipelined restoring divider: an overflow check stage, then one quotient bit per stage, scaled by 2^(FRAC_BITS+1).
module dna_div #(
   parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic [dna_pkg::DIV_STAGES-1:0]       en,
   input  logic [dna_pkg::PROD_W-1:0]           num,
   input  logic [dna_pkg::PROD_W-1:0]           den,
   output logic [dna_pkg::QBITS-1:0]            quo,
   output logic                                 ovf
);
   import dna_pkg::*;

   localparam int RW = PROD_W + FRAC_BITS + 1;
   localparam int HW = PROD_W + 1;

   logic [RW-1:0]     rem_ff [DIV_STAGES-1];
   logic [PROD_W-1:0] d_ff   [DIV_STAGES-1];
   logic [QBITS-1:0]  q_ff   [1:DIV_STAGES-1];
   logic              ovf_ff [DIV_STAGES];
   logic [RW-1:0]     rem0_in;

   // Set up the scaled numerator and flag quotients too large to represent
   assign rem0_in = {num, {(FRAC_BITS + 1){1'b0}}};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= rem0_in;
         d_ff[0]   <= den;
         ovf_ff[0] <= ((rem0_in >> QBITS) >= RW'(den));
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
      localparam int I = QBITS - j;
      localparam logic [RW-1:0] LOW_MASK = (RW'(1) << I) - RW'(1);
      logic [HW-1:0] hi;
      logic [HW-1:0] diff;
      logic          ge;

      assign hi   = HW'(rem_ff[j-1] >> I);
      assign ge   = hi >= {1'b0, d_ff[j-1]};
      assign diff = hi - {1'b0, d_ff[j-1]};

      if (j == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (en[j]) begin
               q_ff[j] <= QBITS'(ge);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en[j]) begin
               q_ff[j] <= {q_ff[j-1][QBITS-2:0], ge};
            end
         end
      end

      if (j < DIV_STAGES - 1) begin : g_rem
         logic [RW-1:0] rem_in;
         assign rem_in = ge ? ((RW'(diff) << I) | (rem_ff[j-1] & LOW_MASK)) : rem_ff[j-1];
         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j] <= rem_in;
               d_ff[j]   <= d_ff[j-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = q_ff[DIV_STAGES-1];
   assign ovf = ovf_ff[DIV_STAGES-1];

endmodule

// ----- design/dual_number_alu.sv -----
// Dual number ALU top level: forward-mode derivative arithmetic on Q16.16 operands.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_data_type (mode, two dual numbers)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data_type (value, gradients, status)
//
// One request enters per cycle while req_stall is low; an accepted request reaches the
// output register after four stages of decode, multiply, sum and magnitude, then the
// divider's 34 stages (overflow check plus one quotient bit each).
// Reset clears only the stage valid bits. A stalled output holds its stage; each
// stage refills as soon as the one after it moves or it holds a bubble, so empty
// stages keep absorbing requests while a result waits.
module dual_number_alu #(
   parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dna_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dna_pkg::rsp_data_type rsp_data
);
   import dna_pkg::*;

   localparam int L  = GRAD_LANES;
   localparam int DS = DIV_STAGES;
   localparam int D0 = 4;
   localparam int NS = D0 + DS + 1;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [QBITS-1:0] QCLIP = QBITS'(1) << (QBITS - 1);

   typedef struct packed {
      logic signed [DATA_W-1:0]        nd_val;
      logic [L-1:0][DATA_W-1:0]        nd_grad;
      logic                            nd_clip;
      logic                            is_div;
      logic                            vzero;
      logic                            qv_neg;
      logic                            u_neg;
      logic [L-1:0]                    g_neg;
   } side_type;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   // Stage enables: a stage moves when empty or when the next stage moves
   for (genvar i = 0; i < NS; i++) begin : g_en
      if (i == NS - 1) begin : g_last
         assign en[i] = !valid_ff[i] || !rsp_stall;
      end else begin : g_mid
         assign en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   // Unpack gradient lanes
   logic signed [DATA_W-1:0] in_du [L];
   logic signed [DATA_W-1:0] in_dv [L];
   assign in_du[0] = req_data.left_grad_0;
   assign in_du[1] = req_data.left_grad_1;
   assign in_du[2] = req_data.left_grad_2;
   assign in_dv[0] = req_data.right_grad_0;
   assign in_dv[1] = req_data.right_grad_1;
   assign in_dv[2] = req_data.right_grad_2;

   // Stage 1: capture operands and their magnitudes
   mode_type                 p1_mode_ff;
   logic signed [DATA_W-1:0] p1_u_ff, p1_v_ff;
   logic signed [DATA_W-1:0] p1_du_ff [L];
   logic signed [DATA_W-1:0] p1_dv_ff [L];
   logic [DATA_W-1:0]        p1_umag_ff, p1_vmag_ff;
   logic [DATA_W-1:0]        p1_dumag_ff [L];
   logic [DATA_W-1:0]        p1_dvmag_ff [L];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_mode_ff <= mode_type'(req_data.mode);
         p1_u_ff    <= req_data.left_value;
         p1_v_ff    <= req_data.right_value;
         p1_umag_ff <= abs32(req_data.left_value);
         p1_vmag_ff <= abs32(req_data.right_value);
         for (int k = 0; k < L; k++) begin
            p1_du_ff[k]    <= in_du[k];
            p1_dv_ff[k]    <= in_dv[k];
            p1_dumag_ff[k] <= abs32(in_du[k]);
            p1_dvmag_ff[k] <= abs32(in_dv[k]);
         end
      end
   end

   // Stage 2: magnitude products and the saturated sum or difference
   mode_type                 p2_mode_ff;
   logic [PROD_W-1:0]        p2_uv_ff, p2_vv_ff;
   logic [PROD_W-1:0]        p2_duv_ff [L];
   logic [PROD_W-1:0]        p2_udv_ff [L];
   logic                     p2_uvneg_ff, p2_uneg_ff;
   logic [L-1:0]             p2_duvneg_ff, p2_udvneg_ff;
   logic [DATA_W-1:0]        p2_umag_ff, p2_vmag_ff;
   logic signed [DATA_W-1:0] p2_asval_ff;
   logic [DATA_W-1:0]        p2_asgrad_ff [L];
   logic                     p2_asclip_ff;

   sat_type                  as_val_in;
   sat_type                  as_grad_in [L];
   logic                     as_clip_in;

   always_comb begin
      logic signed [DATA_W:0] s;
      s = (p1_mode_ff == MODE_SUB) ? ({p1_u_ff[DATA_W-1], p1_u_ff} - {p1_v_ff[DATA_W-1], p1_v_ff})
                                   : ({p1_u_ff[DATA_W-1], p1_u_ff} + {p1_v_ff[DATA_W-1], p1_v_ff});
      as_val_in  = sat_sum(s);
      as_clip_in = as_val_in.clip;
      for (int k = 0; k < L; k++) begin
         s = (p1_mode_ff == MODE_SUB)
             ? ({p1_du_ff[k][DATA_W-1], p1_du_ff[k]} - {p1_dv_ff[k][DATA_W-1], p1_dv_ff[k]})
             : ({p1_du_ff[k][DATA_W-1], p1_du_ff[k]} + {p1_dv_ff[k][DATA_W-1], p1_dv_ff[k]});
         as_grad_in[k] = sat_sum(s);
         as_clip_in    = as_clip_in | as_grad_in[k].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p2_mode_ff   <= p1_mode_ff;
         p2_uv_ff     <= {32'b0, p1_umag_ff} * {32'b0, p1_vmag_ff};
         p2_vv_ff     <= {32'b0, p1_vmag_ff} * {32'b0, p1_vmag_ff};
         p2_uvneg_ff  <= p1_u_ff[DATA_W-1] ^ p1_v_ff[DATA_W-1];
         p2_uneg_ff   <= p1_u_ff[DATA_W-1];
         p2_umag_ff   <= p1_umag_ff;
         p2_vmag_ff   <= p1_vmag_ff;
         p2_asval_ff  <= as_val_in.value;
         p2_asclip_ff <= as_clip_in;
         for (int k = 0; k < L; k++) begin
            p2_duv_ff[k]    <= {32'b0, p1_dumag_ff[k]} * {32'b0, p1_vmag_ff};
            p2_udv_ff[k]    <= {32'b0, p1_umag_ff} * {32'b0, p1_dvmag_ff[k]};
            p2_duvneg_ff[k] <= p1_du_ff[k][DATA_W-1] ^ p1_v_ff[DATA_W-1];
            p2_udvneg_ff[k] <= p1_u_ff[DATA_W-1] ^ p1_dv_ff[k][DATA_W-1];
            p2_asgrad_ff[k] <= as_grad_in[k].value;
         end
      end
   end

   // Stage 3: signed gradient sums (product rule, or quotient rule numerator)
   mode_type                 p3_mode_ff;
   logic [PROD_W-1:0]        p3_uv_ff, p3_vv_ff;
   logic signed [SUM_W-1:0]  p3_gsum_ff [L];
   logic                     p3_uvneg_ff, p3_uneg_ff;
   logic [DATA_W-1:0]        p3_umag_ff, p3_vmag_ff;
   logic signed [DATA_W-1:0] p3_asval_ff;
   logic [DATA_W-1:0]        p3_asgrad_ff [L];
   logic                     p3_asclip_ff;
   logic signed [SUM_W-1:0]  gsum_in [L];

   always_comb begin
      logic signed [SUM_W-1:0] a;
      logic signed [SUM_W-1:0] b;
      for (int k = 0; k < L; k++) begin
         a = {2'b0, p2_duv_ff[k]};
         b = {2'b0, p2_udv_ff[k]};
         if (p2_duvneg_ff[k]) begin
            a = -a;
         end
         if (p2_udvneg_ff[k]) begin
            b = -b;
         end
         gsum_in[k] = (p2_mode_ff == MODE_DIV) ? (a - b) : (a + b);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p3_mode_ff   <= p2_mode_ff;
         p3_uv_ff     <= p2_uv_ff;
         p3_vv_ff     <= p2_vv_ff;
         p3_uvneg_ff  <= p2_uvneg_ff;
         p3_uneg_ff   <= p2_uneg_ff;
         p3_umag_ff   <= p2_umag_ff;
         p3_vmag_ff   <= p2_vmag_ff;
         p3_asval_ff  <= p2_asval_ff;
         p3_asclip_ff <= p2_asclip_ff;
         for (int k = 0; k < L; k++) begin
            p3_gsum_ff[k]   <= gsum_in[k];
            p3_asgrad_ff[k] <= p2_asgrad_ff[k];
         end
      end
   end

   // Stage 4: gradient sums to sign and magnitude
   mode_type                 p4_mode_ff;
   logic [PROD_W-1:0]        p4_uv_ff, p4_vv_ff;
   logic [PROD_W-1:0]        p4_gmag_ff [L];
   logic [L-1:0]             p4_gneg_ff;
   logic                     p4_uvneg_ff, p4_uneg_ff;
   logic [DATA_W-1:0]        p4_umag_ff, p4_vmag_ff;
   logic signed [DATA_W-1:0] p4_asval_ff;
   logic [DATA_W-1:0]        p4_asgrad_ff [L];
   logic                     p4_asclip_ff;
   logic [SUM_W-1:0]         gabs_in [L];

   always_comb begin
      for (int k = 0; k < L; k++) begin
         gabs_in[k] = p3_gsum_ff[k][SUM_W-1] ? SUM_W'(-p3_gsum_ff[k]) : SUM_W'(p3_gsum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         p4_mode_ff   <= p3_mode_ff;
         p4_uv_ff     <= p3_uv_ff;
         p4_vv_ff     <= p3_vv_ff;
         p4_uvneg_ff  <= p3_uvneg_ff;
         p4_uneg_ff   <= p3_uneg_ff;
         p4_umag_ff   <= p3_umag_ff;
         p4_vmag_ff   <= p3_vmag_ff;
         p4_asval_ff  <= p3_asval_ff;
         p4_asclip_ff <= p3_asclip_ff;
         for (int k = 0; k < L; k++) begin
            p4_gmag_ff[k]   <= gabs_in[k][PROD_W-1:0];
            p4_gneg_ff[k]   <= p3_gsum_ff[k][SUM_W-1];
            p4_asgrad_ff[k] <= p3_asgrad_ff[k];
         end
      end
   end

   // Dividers: value lane u/v, gradient lanes numerator/v^2
   logic [QBITS-1:0] quo_val;
   logic             ovf_val;
   logic [QBITS-1:0] quo_grad [L];
   logic [L-1:0]     ovf_grad;

   dna_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div_val (
      .clock (clock),
      .en    (en[D0 +: DS]),
      .num   ({32'b0, p4_umag_ff}),
      .den   ({32'b0, p4_vmag_ff}),
      .quo   (quo_val),
      .ovf   (ovf_val)
   );

   for (genvar k = 0; k < L; k++) begin : g_div
      dna_div #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div_grad (
         .clock (clock),
         .en    (en[D0 +: DS]),
         .num   (p4_gmag_ff[k]),
         .den   (p4_vv_ff),
         .quo   (quo_grad[k]),
         .ovf   (ovf_grad[k])
      );
   end

   // Side data: round the products and pick the non-divide result
   side_type side_in;
   side_type side_ff [DS];

   always_comb begin
      sat_type mv;
      sat_type mg;
      side_in.is_div = (p4_mode_ff == MODE_DIV);
      side_in.vzero  = (p4_vmag_ff == '0);
      side_in.qv_neg = p4_uvneg_ff;
      side_in.u_neg  = p4_uneg_ff;
      side_in.g_neg  = p4_gneg_ff;
      mv = sat_mag(p4_uvneg_ff, (p4_uv_ff + HALF) >> FRAC_BITS);
      if (p4_mode_ff == MODE_MUL) begin
         side_in.nd_val  = mv.value;
         side_in.nd_clip = mv.clip;
      end else begin
         side_in.nd_val  = p4_asval_ff;
         side_in.nd_clip = p4_asclip_ff;
      end
      for (int k = 0; k < L; k++) begin
         mg = sat_mag(p4_gneg_ff[k], (p4_gmag_ff[k] + HALF) >> FRAC_BITS);
         if (p4_mode_ff == MODE_MUL) begin
            side_in.nd_grad[k] = mg.value;
            side_in.nd_clip    = side_in.nd_clip | mg.clip;
         end else begin
            side_in.nd_grad[k] = p4_asgrad_ff[k];
         end
      end
   end

   // Carry side data alongside the divider stages
   always_ff @(posedge clock) begin
      if (en[D0]) begin
         side_ff[0] <= side_in;
      end
      for (int j = 1; j < DS; j++) begin
         if (en[D0 + j]) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // Output stage: round and clip quotients, saturate on a zero divisor, or take the non-divide result
   rsp_data_type out_in;
   rsp_data_type out_ff;

   always_comb begin
      side_type                 sd;
      logic [QBITS:0]           inc;
      logic [QBITS-1:0]         q;
      sat_type                  qs;
      logic                     clip;
      logic signed [DATA_W-1:0] res_val;
      logic [L-1:0][DATA_W-1:0] res_grad;
      sd       = side_ff[DS-1];
      inc      = '0;
      q        = '0;
      qs       = '0;
      res_val  = sd.nd_val;
      res_grad = sd.nd_grad;
      clip     = sd.nd_clip;
      if (sd.is_div) begin
         if (sd.vzero) begin
            res_val = sd.u_neg ? NEG_LIMIT : POS_LIMIT;
            for (int k = 0; k < L; k++) begin
               res_grad[k] = sd.g_neg[k] ? NEG_LIMIT : POS_LIMIT;
            end
         end else begin
            inc     = {1'b0, quo_val} + (QBITS + 1)'(1);
            q       = ovf_val ? QCLIP : inc[QBITS:1];
            qs      = sat_mag(sd.qv_neg, PROD_W'(q));
            res_val = qs.value;
            clip    = qs.clip;
            for (int k = 0; k < L; k++) begin
               inc         = {1'b0, quo_grad[k]} + (QBITS + 1)'(1);
               q           = ovf_grad[k] ? QCLIP : inc[QBITS:1];
               qs          = sat_mag(sd.g_neg[k], PROD_W'(q));
               res_grad[k] = qs.value;
               clip        = clip | qs.clip;
            end
         end
      end
      out_in.result_value  = res_val;
      out_in.result_grad_0 = res_grad[0];
      out_in.result_grad_1 = res_grad[1];
      out_in.result_grad_2 = res_grad[2];
      if (sd.is_div && sd.vzero) begin
         out_in.status = STAT_DZ;
      end else if (clip) begin
         out_in.status = STAT_SAT;
      end else begin
         out_in.status = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule
